>>> rtl/core/pcd_pkg.sv
package pcd_pkg;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam int GROUP_SIZE = 16;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  entry_slot;
        logic [7:0]  entry_symbol;
        logic [4:0]  entry_code_length;
        logic [15:0] entry_code;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       error;
    } t_out_item;

    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_q_head;

endpackage

>>> rtl/core/prefix_code_table_decoder.sv
// Table-driven prefix-code decoder. Load transactions fill the code table, a start
// transaction clears the pending bits and arms the lead pad skip, and each data
// byte is decoded MSB first. In S_BIT the candidate prefix of each stream bit is
// compared against all table slots, and S_PICK then picks the lowest matching slot;
// a skipped or an overrun bit is handled in S_BIT alone. A data byte is fetched
// in S_IDLE, its bits are decoded, S_BIT sees the byte is spent and S_FLUSH
// releases the final result. A two-entry queue in front and an output register
// behind let either side stall.
module prefix_code_table_decoder #(
    parameter int TABLE_SLOTS  = 256,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pcd_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output pcd_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_data
);

    pcd_pkg::t_q_head head;
    logic             pop;
    logic [2:0]       r_lead_pad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_pad <= 3'd0;
        end else if (i_cfg_valid) begin
            r_lead_pad <= i_cfg_data;
        end
    end

    pcd_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_head  (head),
        .i_pop   (pop)
    );

    pcd_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .i_lead_pad (r_lead_pad),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule

>>> rtl/core/pcd_front.sv
module pcd_front #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pcd_pkg::t_in_item i_data,
    output pcd_pkg::t_q_head  o_head,
    input  logic              i_pop
);

    pcd_pkg::t_in_item r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic              keep;
    logic              push;
    logic              pop;

    always_comb begin
        keep = (i_data.op == pcd_pkg::OP_DATA) || (i_data.op == pcd_pkg::OP_START) ||
               ((i_data.op == pcd_pkg::OP_LOAD) && (9'(i_data.entry_slot) < 9'(TABLE_SLOTS)));
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready && keep;
    assign pop         = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

>>> rtl/core/pcd_back.sv
module pcd_back #(
    parameter int TABLE_SLOTS  = 256,
    parameter int MAX_CODE_LEN = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcd_pkg::t_q_head   i_head,
    output logic               o_pop,
    input  logic [2:0]         i_lead_pad,
    output logic               o_valid,
    input  logic               i_ready,
    output pcd_pkg::t_out_item o_data
);

    localparam int SW   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW   = $clog2(MAX_CODE_LEN + 1);
    localparam int NG   = (TABLE_SLOTS + pcd_pkg::GROUP_SIZE - 1) / pcd_pkg::GROUP_SIZE;
    localparam int CMPW = (MAX_CODE_LEN > 16) ? MAX_CODE_LEN : 16;

    typedef enum logic [2:0] {S_IDLE, S_BIT, S_PICK, S_FLUSH} t_state;

    t_state              r_state;
    logic [4:0]          r_tlen  [TABLE_SLOTS];
    logic [15:0]         r_tcode [TABLE_SLOTS];
    logic [7:0]          r_tsym  [TABLE_SLOTS];
    logic [7:0]          r_byte;
    logic [3:0]          r_left;
    logic [2:0]          r_skip;
    logic [MAX_CODE_LEN-1:0] r_pbits;
    logic [CW-1:0]       r_pcnt;
    logic [MAX_CODE_LEN-1:0] r_cbits;
    logic [CW-1:0]       r_ccnt;
    logic                r_gany [NG];
    logic [7:0]          r_gsym [NG];
    logic                r_hv;
    logic [7:0]          r_hsym;
    logic                r_herr;
    logic                r_ov;
    pcd_pkg::t_out_item  r_od;

    logic [MAX_CODE_LEN-1:0] c_bits;
    logic [CW-1:0]       c_cnt;
    logic                g_any [NG];
    logic [7:0]          g_sym [NG];
    logic                p_any;
    logic [7:0]          p_sym;
    logic                gen_v;
    logic                gen_err;
    logic [7:0]          gen_sym;
    logic                out_free;
    logic                stall;
    logic                push;
    logic                overrun;
    logic [15:0]         load_mask;

    assign c_cnt   = r_pcnt + CW'(1);
    assign c_bits  = (r_pbits << 1) | MAX_CODE_LEN'(r_byte[7]);
    assign overrun = (r_pcnt >= CW'(MAX_CODE_LEN));
    assign load_mask = (i_head.item.entry_code_length >= 5'd16) ? 16'hFFFF :
                       ((16'd1 << i_head.item.entry_code_length) - 16'd1);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            g_any[g] = 1'b0;
            g_sym[g] = 8'd0;
            for (int k = pcd_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
                if (g * pcd_pkg::GROUP_SIZE + k < TABLE_SLOTS) begin
                    if ((6'(r_tlen[g * pcd_pkg::GROUP_SIZE + k]) == 6'(c_cnt)) &&
                        (CMPW'(r_tcode[g * pcd_pkg::GROUP_SIZE + k]) == CMPW'(c_bits))) begin
                        g_any[g] = 1'b1;
                        g_sym[g] = r_tsym[g * pcd_pkg::GROUP_SIZE + k];
                    end
                end
            end
        end
        p_any = 1'b0;
        p_sym = 8'd0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_gany[g]) begin
                p_any = 1'b1;
                p_sym = r_gsym[g];
            end
        end
    end

    always_comb begin
        gen_v   = 1'b0;
        gen_err = 1'b0;
        gen_sym = 8'd0;
        if (r_state == S_BIT && r_left != 4'd0 && r_skip == 3'd0 && overrun) begin
            gen_v   = 1'b1;
            gen_err = 1'b1;
        end else if (r_state == S_PICK && p_any) begin
            gen_v   = 1'b1;
            gen_sym = p_sym;
        end
    end

    assign out_free = !r_ov || i_ready;
    assign stall    = ((gen_v && r_hv) || (r_state == S_FLUSH && r_hv)) && !out_free;
    assign push     = r_hv && !stall && (gen_v || r_state == S_FLUSH);
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;
    assign o_valid  = r_ov;
    assign o_data   = r_od;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_od.symbol <= r_hsym;
            r_od.error  <= r_herr;
            r_od.last   <= (r_state == S_FLUSH);
        end
        if (r_state == S_BIT) begin
            r_cbits <= c_bits;
            r_ccnt  <= c_cnt;
            for (int g = 0; g < NG; g++) begin
                r_gany[g] <= g_any[g];
                r_gsym[g] <= g_sym[g];
            end
        end
        if (gen_v && !stall) begin
            r_hsym <= gen_sym;
            r_herr <= gen_err;
        end
        if (o_pop && i_head.item.op == pcd_pkg::OP_LOAD) begin
            r_tcode[i_head.item.entry_slot[SW-1:0]] <= i_head.item.entry_code & load_mask;
            r_tsym[i_head.item.entry_slot[SW-1:0]]  <= i_head.item.entry_symbol;
        end
        if (o_pop && i_head.item.op == pcd_pkg::OP_DATA) begin
            r_byte <= i_head.item.data_byte;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= 4'd0;
            r_skip  <= 3'd0;
            r_pbits <= '0;
            r_pcnt  <= '0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                r_tlen[s] <= 5'd0;
            end
        end else begin
            if (push) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_head.item.op)
                            pcd_pkg::OP_LOAD: begin
                                r_tlen[i_head.item.entry_slot[SW-1:0]] <=
                                    i_head.item.entry_code_length;
                            end
                            pcd_pkg::OP_START: begin
                                r_pbits <= '0;
                                r_pcnt  <= '0;
                                r_skip  <= i_lead_pad;
                            end
                            pcd_pkg::OP_DATA: begin
                                r_left  <= 4'd8;
                                r_state <= S_BIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_BIT: begin
                    if (r_left == 4'd0) begin
                        r_state <= S_FLUSH;
                    end else if (r_skip != 3'd0) begin
                        r_skip <= r_skip - 3'd1;
                        r_byte <= r_byte << 1;
                        r_left <= r_left - 4'd1;
                    end else if (overrun) begin
                        if (!stall) begin
                            r_pbits <= '0;
                            r_pcnt  <= '0;
                            r_hv    <= 1'b1;
                            r_byte  <= r_byte << 1;
                            r_left  <= r_left - 4'd1;
                        end
                    end else begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (!stall) begin
                        if (p_any) begin
                            r_pbits <= '0;
                            r_pcnt  <= '0;
                            r_hv    <= 1'b1;
                        end else begin
                            r_pbits <= r_cbits;
                            r_pcnt  <= r_ccnt;
                        end
                        r_byte  <= r_byte << 1;
                        r_left  <= r_left - 4'd1;
                        r_state <= S_BIT;
                    end
                end
                S_FLUSH: begin
                    if (!stall) begin
                        r_hv    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_pcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= CW'(MAX_CODE_LEN))
        else $error("pending count above maximum code length");

    a_pick_follows_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PICK |-> ($past(r_state) == S_BIT || $past(r_state) == S_PICK))
        else $error("pick without compare");

    a_idle_no_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hv)
        else $error("held transaction left behind");

    a_error_zero_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.error) |-> (o_data.symbol == 8'd0))
        else $error("error transaction with nonzero symbol");

endmodule
